// ----- rtl/assert_macros.svh -----
// assertion macros shared by the deframer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/mqfd_pkg.sv -----
// package with widths, codes and types of the fixed header deframer
package mqfd_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 28;
  localparam int MAXSZ_W    = 29;
  localparam int ROLE_W     = 2;
  localparam int ERR_W      = 2;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_MAX_LENGTH_BYTES = 4;

  // byte roles
  localparam logic [ROLE_W-1:0] ROLE_COMMAND = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;
  localparam logic [ROLE_W-1:0] ROLE_DISCARD = 2'd3;

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_LEN_LONG = 2'd1;
  localparam logic [ERR_W-1:0] ERR_CONNECT  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_OVERSIZE = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LIMIT      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_CONNECT = 8'd1;

  // upper nibble of a connect command
  localparam logic [3:0] CONNECT_NIBBLE = 4'h1;

  typedef struct packed {
    logic [MAXSZ_W-1:0] size_limit;
    logic               require_connect_first;
  } cfg_t;

  typedef struct packed {
    logic [ROLE_W-1:0] byte_role;
    logic [BYTE_W-1:0] data_out;
    logic [LEN_W-1:0]  payload_offset;
    logic [BYTE_W-1:0] command_out;
    logic [LEN_W-1:0]  length_out;
    logic              packet_end;
    logic [ERR_W-1:0]  error_code;
  } res_t;

endpackage

// ----- rtl/mqfd_ifs.sv -----
// stream and configuration interfaces of the deframer

interface mqfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [mqfd_pkg::BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mqfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mqfd_pkg::ROLE_W-1:0] byte_role;
  logic [mqfd_pkg::BYTE_W-1:0] data_out;
  logic [mqfd_pkg::LEN_W-1:0]  payload_offset;
  logic [mqfd_pkg::BYTE_W-1:0] command_out;
  logic [mqfd_pkg::LEN_W-1:0]  length_out;
  logic                        packet_end;
  logic [mqfd_pkg::ERR_W-1:0]  error_code;
  modport source (output valid, output byte_role, output data_out, output payload_offset,
                  output command_out, output length_out, output packet_end,
                  output error_code, input ready);
  modport sink (input valid, input byte_role, input data_out, input payload_offset,
                input command_out, input length_out, input packet_end,
                input error_code, output ready);
endinterface

interface mqfd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mqfd_pkg::CFG_IDX_W-1:0]  index;
  logic [mqfd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/mqtt_fixed_header_deframer.sv -----
// Fixed header deframer: splits a received byte stream into protocol packets.
// Channels: in_ch carries one received byte per word, out_ch one tagged result
// word per byte (role, byte, payload offset, command, length, end mark, error),
// cfg_ch writes the two registers (index 0 max packet size, 1 require connect).
// All three use valid/ready; a word moves when both are high.
// Pipeline: input register holds the byte, output register its result word.
// Throughput: one byte per cycle unless out_ch stalls, set by the combinational
// update of the framing state (length accumulate and compare, payload down
// count). Stall: when out_ch is not ready the output register holds its word,
// the input register fills, and in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous) clears both pipeline registers, the framing
// state, the sticky error and the registers (size check off, no connect rule).
// After an error every later byte comes out as discarded until reset.
// cfg_ch is always ready; the user must write registers only while the block is
// idle, as the block itself does not enforce it.
`include "assert_macros.svh"

module mqtt_fixed_header_deframer #(
  parameter int MAX_LENGTH_BYTES = mqfd_pkg::DEF_MAX_LENGTH_BYTES
) (
  input logic        clk,
  input logic        rst_n,
  mqfd_in_if.sink    in_ch,
  mqfd_out_if.source out_ch,
  mqfd_cfg_if.sink   cfg_ch
);

  mqfd_pkg::cfg_t              cfg;
  mqfd_pkg::res_t              res;
  mqfd_pkg::res_t              out_res_r;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [mqfd_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        out_valid_r, out_valid_nxt;
  logic                        in_take;
  logic                        advance;

  mqfd_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  mqfd_core #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (advance),
    .rx_byte (s1_byte_r),
    .res     (res)
  );

  // handshake: input register moves on when the output register is free
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.byte_role      = out_res_r.byte_role;
  assign out_ch.data_out       = out_res_r.data_out;
  assign out_ch.payload_offset = out_res_r.payload_offset;
  assign out_ch.command_out    = out_res_r.command_out;
  assign out_ch.length_out     = out_res_r.length_out;
  assign out_ch.packet_end     = out_res_r.packet_end;
  assign out_ch.error_code     = out_res_r.error_code;

  // pipeline checks
  `ASSERT_CLK(a_in_stall, !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready), "input stalled with room in the pipeline")
  `ASSERT_CLK(a_advance_out, advance |=> out_valid_r, "decoded word not presented")

endmodule

// ----- rtl/mqfd_cfg_regs.sv -----
// configuration registers of the deframer
module mqfd_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  mqfd_cfg_if.sink         cfg_ch,
  output mqfd_pkg::cfg_t   cfg
);

  mqfd_pkg::cfg_t cfg_r;
  mqfd_pkg::cfg_t cfg_nxt;
  logic           wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en = cfg_ch.valid && cfg_ch.ready;

  // decode the write, unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_ch.index)
        mqfd_pkg::REG_SIZE_LIMIT: begin
          cfg_nxt.size_limit = cfg_ch.data[mqfd_pkg::MAXSZ_W-1:0];
        end
        mqfd_pkg::REG_REQUIRE_CONNECT: begin
          cfg_nxt.require_connect_first = cfg_ch.data[0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/mqfd_core.sv -----
// framing state and per-byte decode of the deframer
`include "assert_macros.svh"

module mqfd_core #(
  parameter int MAX_LENGTH_BYTES = mqfd_pkg::DEF_MAX_LENGTH_BYTES
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mqfd_pkg::cfg_t              cfg,
  input  logic                        step,
  input  logic [mqfd_pkg::BYTE_W-1:0] rx_byte,
  output mqfd_pkg::res_t              res
);

  localparam logic [1:0] PH_COMMAND = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [mqfd_pkg::CNT_W-1:0] CNT_MAX = mqfd_pkg::CNT_W'(MAX_LENGTH_BYTES);

  logic [1:0]                   phase_r, phase_nxt;
  logic [mqfd_pkg::BYTE_W-1:0]  command_r, command_nxt;
  logic [mqfd_pkg::LEN_W-1:0]   accum_r, accum_nxt;
  logic [mqfd_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [mqfd_pkg::LEN_W-1:0]   left_r, left_nxt;
  logic                         seen_r, seen_nxt;
  logic [mqfd_pkg::ERR_W-1:0]   err_r, err_nxt;

  logic [mqfd_pkg::CNT_W-1:0]   count_inc;
  logic [mqfd_pkg::LEN_W-1:0]   addend;
  logic [mqfd_pkg::LEN_W-1:0]   sum;
  logic [mqfd_pkg::MAXSZ_W-1:0] len_plus1;
  logic                         pkt_end;

  // place the 7 length bits of this byte at its group position
  always_comb begin
    case (count_r[1:0])
      2'd0:    addend = {21'b0, rx_byte[6:0]};
      2'd1:    addend = {14'b0, rx_byte[6:0], 7'b0};
      2'd2:    addend = {7'b0, rx_byte[6:0], 14'b0};
      default: addend = {rx_byte[6:0], 21'b0};
    endcase
  end

  assign count_inc = count_r + 3'd1;
  assign sum       = accum_r + addend;
  assign len_plus1 = {1'b0, sum} + 29'd1;

  // next state and result word for one byte
  always_comb begin
    phase_nxt   = phase_r;
    command_nxt = command_r;
    accum_nxt   = accum_r;
    count_nxt   = count_r;
    left_nxt    = left_r;
    seen_nxt    = seen_r;
    err_nxt     = err_r;
    pkt_end     = 1'b0;
    res.byte_role      = mqfd_pkg::ROLE_DISCARD;
    res.payload_offset = '0;

    if (err_r == mqfd_pkg::ERR_NONE) begin
      case (phase_r)
        PH_LENGTH: begin
          res.byte_role = mqfd_pkg::ROLE_LENGTH;
          count_nxt     = count_inc;
          if (count_inc > CNT_MAX || count_inc == '0) begin
            err_nxt = mqfd_pkg::ERR_LEN_LONG;
          end else begin
            accum_nxt = sum;
            if (!rx_byte[7]) begin
              if (cfg.size_limit != '0 && len_plus1 > cfg.size_limit) begin
                err_nxt = mqfd_pkg::ERR_OVERSIZE;
              end else if (sum == '0) begin
                pkt_end = 1'b1;
              end else begin
                left_nxt  = sum;
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          res.byte_role      = mqfd_pkg::ROLE_PAYLOAD;
          res.payload_offset = accum_r - left_r;
          left_nxt           = left_r - 28'd1;
          pkt_end            = (left_nxt == '0);
        end
        default: begin
          res.byte_role = mqfd_pkg::ROLE_COMMAND;
          command_nxt   = rx_byte;
          accum_nxt     = '0;
          count_nxt     = '0;
          left_nxt      = '0;
          if (cfg.require_connect_first && !seen_r &&
              rx_byte[7:4] != mqfd_pkg::CONNECT_NIBBLE) begin
            err_nxt = mqfd_pkg::ERR_CONNECT;
          end else begin
            seen_nxt  = 1'b1;
            phase_nxt = PH_LENGTH;
          end
        end
      endcase
    end

    res.data_out    = rx_byte;
    res.command_out = command_nxt;
    res.length_out  = accum_nxt;
    res.packet_end  = pkt_end;
    res.error_code  = err_nxt;

    // packet done, clear for the next command byte
    if (pkt_end) begin
      phase_nxt   = PH_COMMAND;
      command_nxt = '0;
      accum_nxt   = '0;
      count_nxt   = '0;
      left_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_COMMAND;
      command_r <= '0;
      accum_r   <= '0;
      count_r   <= '0;
      left_r    <= '0;
      seen_r    <= 1'b0;
      err_r     <= mqfd_pkg::ERR_NONE;
    end else if (step) begin
      phase_r   <= phase_nxt;
      command_r <= command_nxt;
      accum_r   <= accum_nxt;
      count_r   <= count_nxt;
      left_r    <= left_nxt;
      seen_r    <= seen_nxt;
      err_r     <= err_nxt;
    end
  end

  // checks on the framing state
  `ASSERT_CLK(a_err_sticky, err_r != mqfd_pkg::ERR_NONE |=> err_r == $past(err_r), "error moved")
  `ASSERT_CLK(a_payload_left, phase_r == PH_PAYLOAD |-> left_r != '0, "empty payload phase")
  `ASSERT_CLK(a_payload_err, phase_r == PH_PAYLOAD |-> err_r == mqfd_pkg::ERR_NONE, "payload err")
  `ASSERT_CLK(a_count_bound, err_r == mqfd_pkg::ERR_NONE |-> count_r <= CNT_MAX, "count past max")

endmodule

// ----- sim/tb_mqtt_fixed_header_deframer.sv -----
// self-checking testbench for the fixed header deframer
module tb_mqtt_fixed_header_deframer;

  localparam int          HALF_PERIOD    = 6;
  localparam int          RESET_CYCLES   = 4;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          SETTLE_CYCLES  = 4;
  localparam int          MISMATCH_SHOWN = 10;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int          PHASE_BYTES    = 250;
  localparam int          DISCARD_BYTES  = 30;
  localparam int          FIXED_PHASES   = 5;
  localparam logic [mqfd_pkg::CFG_IDX_W-1:0] REG_UNLISTED =
    mqfd_pkg::REG_REQUIRE_CONNECT + 8'd1;
  localparam logic [mqfd_pkg::CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

  // framing states of the predictor
  localparam logic [1:0] ST_COMMAND = 2'd0;
  localparam logic [1:0] ST_LENGTH  = 2'd1;
  localparam logic [1:0] ST_PAYLOAD = 2'd2;

  // how the run ends up stuck
  typedef enum logic [1:0] {
    STICK_CONNECT  = 2'd0,
    STICK_LEN_LONG = 2'd1,
    STICK_OVERSIZE = 2'd2
  } stick_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  mqfd_in_if  in_if ();
  mqfd_out_if out_if ();
  mqfd_cfg_if cfg_if ();

  mqtt_fixed_header_deframer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // register copies
  logic [mqfd_pkg::MAXSZ_W-1:0] max_size = '0;
  logic                         need_connect = 1'b0;

  // framing state copy
  logic [1:0]                  fstate = ST_COMMAND;
  logic [mqfd_pkg::BYTE_W-1:0] cmd_reg = '0;
  logic [mqfd_pkg::LEN_W-1:0]  len_acc = '0;
  logic [mqfd_pkg::CNT_W-1:0]  len_bytes = '0;
  logic [mqfd_pkg::LEN_W-1:0]  pay_left = '0;
  logic                        first_seen = 1'b0;
  logic [mqfd_pkg::ERR_W-1:0]  stuck_err = mqfd_pkg::ERR_NONE;

  // byte stream to send and tagged words still owed by the block
  logic [mqfd_pkg::BYTE_W-1:0] tx_bytes[$];
  mqfd_pkg::res_t              owed_words[$];
  int unsigned       queued_cnt = 0;
  int unsigned       accepted_cnt = 0;
  int unsigned       mismatch_cnt = 0;
  int unsigned       cycle_cnt = 0;

  logic              in_taken = 1'b0;
  int unsigned       burst_left = 0;
  int unsigned       gap_left = 0;
  logic              hold_off = 1'b0;
  logic [7:0]        stall_pat = 8'hFF;
  logic [5:0]        stall_cnt = '0;
  event              hold_go;

  // tag one byte and advance the framing state
  function automatic mqfd_pkg::res_t frame_byte(input logic [mqfd_pkg::BYTE_W-1:0] b);
    mqfd_pkg::res_t r;
    logic [4:0]     shift;
    r = '0;
    r.byte_role = mqfd_pkg::ROLE_DISCARD;
    r.data_out  = b;
    if (stuck_err == mqfd_pkg::ERR_NONE) begin
      case (fstate)
        ST_LENGTH: begin
          r.byte_role = mqfd_pkg::ROLE_LENGTH;
          len_bytes = len_bytes + 3'd1;
          if (len_bytes > mqfd_pkg::DEF_MAX_LENGTH_BYTES || len_bytes == 0) begin
            stuck_err = mqfd_pkg::ERR_LEN_LONG;
          end else begin
            shift   = 5'(7 * ((len_bytes - 3'd1) & 3'd3));
            len_acc = len_acc + (mqfd_pkg::LEN_W'(b[6:0]) << shift);
            if (!b[7]) begin
              if (max_size != 0 && mqfd_pkg::MAXSZ_W'(len_acc) + 1 > max_size) begin
                stuck_err = mqfd_pkg::ERR_OVERSIZE;
              end else if (len_acc == 0) begin
                r.packet_end = 1'b1;
              end else begin
                pay_left = len_acc;
                fstate   = ST_PAYLOAD;
              end
            end
          end
        end
        ST_PAYLOAD: begin
          r.byte_role      = mqfd_pkg::ROLE_PAYLOAD;
          r.payload_offset = len_acc - pay_left;
          pay_left         = pay_left - 1'b1;
          r.packet_end     = (pay_left == 0);
        end
        default: begin
          r.byte_role = mqfd_pkg::ROLE_COMMAND;
          cmd_reg   = b;
          len_acc   = '0;
          len_bytes = '0;
          pay_left  = '0;
          if (need_connect && !first_seen && b[7:4] != mqfd_pkg::CONNECT_NIBBLE) begin
            stuck_err = mqfd_pkg::ERR_CONNECT;
          end else begin
            first_seen = 1'b1;
            fstate     = ST_LENGTH;
          end
        end
      endcase
    end
    r.command_out = cmd_reg;
    r.length_out  = len_acc;
    r.error_code  = stuck_err;
    // packet done: forget it once reported
    if (r.packet_end) begin
      cmd_reg   = '0;
      len_acc   = '0;
      len_bytes = '0;
      pay_left  = '0;
      fstate    = ST_COMMAND;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input mqfd_pkg::res_t want,
                               input mqfd_pkg::res_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= MISMATCH_SHOWN) begin
      $display("mismatch (%s) at cycle %0d", what, cycle_cnt);
      $display("  want role=%0d byte=%02h off=%0d cmd=%02h len=%0d end=%0d err=%0d",
               want.byte_role, want.data_out, want.payload_offset, want.command_out,
               want.length_out, want.packet_end, want.error_code);
      $display("  got  role=%0d byte=%02h off=%0d cmd=%02h len=%0d end=%0d err=%0d",
               got.byte_role, got.data_out, got.payload_offset, got.command_out,
               got.length_out, got.packet_end, got.error_code);
    end
  endtask

  // monitor: check result words, then predict for accepted bytes
  always @(posedge clk) begin
    mqfd_pkg::res_t got;
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[mqtt_fixed_header_deframer] ERROR");
      $finish;
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      got.byte_role      = out_if.byte_role;
      got.data_out       = out_if.data_out;
      got.payload_offset = out_if.payload_offset;
      got.command_out    = out_if.command_out;
      got.length_out     = out_if.length_out;
      got.packet_end     = out_if.packet_end;
      got.error_code     = out_if.error_code;
      if (owed_words.size() == 0) begin
        note_mismatch("word with none owed", '0, got);
      end else if (got !== owed_words[0]) begin
        note_mismatch("field", owed_words.pop_front(), got);
      end else begin
        void'(owed_words.pop_front());
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      owed_words.push_back(frame_byte(in_if.rx_byte));
      accepted_cnt++;
    end
    in_taken <= rst_n && in_if.valid && in_if.ready;
  end

  // driver: bursts of bytes with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid   <= 1'b0;
      in_if.rx_byte <= '0;
    end else if (in_if.valid && !in_taken) begin
      // word still waiting, hold it
    end else if (gap_left != 0) begin
      in_if.valid <= 1'b0;
      gap_left--;
    end else if (tx_bytes.size() != 0) begin
      in_if.valid   <= 1'b1;
      in_if.rx_byte <= tx_bytes.pop_front();
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      end else begin
        burst_left--;
      end
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // receiver stalls on a pattern that changes each time the 6-bit stall counter wraps
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 6'd1;
    if (stall_cnt == 0) begin
      stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    out_if.ready <= !hold_off && stall_pat[stall_cnt[2:0]];
  end

  // long receiver hold-off
  always begin
    @(hold_go);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  task automatic queue_byte(input logic [mqfd_pkg::BYTE_W-1:0] b);
    tx_bytes.push_back(b);
    queued_cnt++;
  endtask

  // command plus length bytes, optionally padded with empty continuation groups
  task automatic queue_header(input logic [mqfd_pkg::BYTE_W-1:0] cmd,
                              input int unsigned len, input int unsigned pad);
    int unsigned groups;
    int unsigned total;
    queue_byte(cmd);
    groups = 1;
    while (groups < mqfd_pkg::DEF_MAX_LENGTH_BYTES && (len >> (7 * groups)) != 0) groups++;
    total = groups + pad;
    if (total > mqfd_pkg::DEF_MAX_LENGTH_BYTES) total = mqfd_pkg::DEF_MAX_LENGTH_BYTES;
    for (int unsigned i = 0; i < total; i++) begin
      queue_byte({(i < total - 1), 7'(len >> (7 * i))});
    end
  endtask

  task automatic queue_packet(input logic [mqfd_pkg::BYTE_W-1:0] cmd,
                              input int unsigned len, input int unsigned pad);
    queue_header(cmd, len, pad);
    for (int unsigned i = 0; i < len; i++) queue_byte(8'($urandom));
  endtask

  // well-formed packets that stay within the size limit
  task automatic queue_random_packets(input int unsigned n_bytes);
    int unsigned goal;
    int unsigned lim;
    int unsigned len;
    goal = queued_cnt + n_bytes;
    lim  = (max_size == 0 || max_size > 301) ? 300 : max_size - 1;
    while (queued_cnt < goal) begin
      case ($urandom_range(0, 7))
        0: len = 0;
        7: len = $urandom_range(0, lim);
        default: len = $urandom_range(0, (lim < 40) ? lim : 40);
      endcase
      queue_packet(8'($urandom), len,
                   ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
    end
  endtask

  task automatic write_reg(input logic [mqfd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mqfd_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      mqfd_pkg::REG_SIZE_LIMIT: max_size = val[mqfd_pkg::MAXSZ_W-1:0];
      mqfd_pkg::REG_REQUIRE_CONNECT: need_connect = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // all bytes accepted and all words back, then let the pipeline drain
  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != queued_cnt || owed_words.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // stimulus
  initial begin
    stick_kind_t                 stick;
    int unsigned                 hold_phase;
    int unsigned                 nib;
    int unsigned                 limit_sz;
    logic [mqfd_pkg::BYTE_W-1:0] cmd;
    rst_n        = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    stick = ($urandom_range(0, 4) == 0) ? STICK_CONNECT :
            ($urandom_range(0, 1) == 0) ? STICK_LEN_LONG : STICK_OVERSIZE;
    hold_phase = $urandom_range(0, FIXED_PHASES - 1);
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // connect rule on, size register at its full width
    write_reg(mqfd_pkg::REG_REQUIRE_CONNECT, 32'd1);
    write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'hFFFF_FFFF);
    if (stick == STICK_CONNECT) begin
      nib = $urandom_range(0, 14);
      if (nib >= mqfd_pkg::CONNECT_NIBBLE) nib++;
      queue_byte({4'(nib), 4'($urandom)});
    end else begin
      queue_packet({mqfd_pkg::CONNECT_NIBBLE, 4'hF}, 0, 0);
    end
    // zero length spread over all four length bytes
    queue_packet(8'hFF, 0, 3);
    // payload extremes
    queue_byte(8'h30);
    queue_byte(8'h02);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_packet(8'h00, 1, 1);
    wait_idle();

    // tight limit: length just under it passes, rule bit cleared, upper bits set
    write_reg(mqfd_pkg::REG_REQUIRE_CONNECT, 32'hFFFF_FFFE);
    write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'd4);
    write_reg(REG_UNLISTED, 32'hFFFF_FFFF);
    write_reg(REG_TOP_IDX, 32'd0);
    queue_packet(8'h82, 3, 0);
    queue_packet(8'hC0, 0, 0);
    wait_idle();

    // random phases over several settings
    for (int unsigned p = 0; p < FIXED_PHASES; p++) begin
      case (p)
        0: write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'd0);
        1: write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'h1000_0000);
        2: write_reg(mqfd_pkg::REG_SIZE_LIMIT, $urandom_range(2, 64));
        3: write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'd1);
        default: write_reg(mqfd_pkg::REG_SIZE_LIMIT, $urandom_range(65, 400));
      endcase
      write_reg(mqfd_pkg::REG_REQUIRE_CONNECT, 32'($urandom_range(0, 1)));
      if (p == hold_phase) -> hold_go;
      queue_random_packets(PHASE_BYTES);
      wait_idle();
    end

    // drive the block into its sticky error if not yet in it, then feed discards
    cmd = 8'($urandom);
    if (stick == STICK_LEN_LONG) begin
      queue_byte(cmd);
      repeat (mqfd_pkg::DEF_MAX_LENGTH_BYTES) queue_byte({1'b1, 7'($urandom)});
      queue_byte(8'($urandom));
    end else if (stick == STICK_OVERSIZE) begin
      if ($urandom_range(0, 1) == 0) begin
        write_reg(mqfd_pkg::REG_SIZE_LIMIT, 32'h0FFF_FFFF);
        queue_header(cmd, 32'h0FFF_FFFF, 0);
      end else begin
        limit_sz = $urandom_range(1, 300);
        write_reg(mqfd_pkg::REG_SIZE_LIMIT, limit_sz);
        queue_header(cmd, $urandom_range(limit_sz, limit_sz + 200), 0);
      end
    end
    repeat (DISCARD_BYTES) queue_byte(8'($urandom));
    wait_idle();

    if (mismatch_cnt == 0) begin
      $display("[mqtt_fixed_header_deframer] OK");
    end else begin
      $display("[mqtt_fixed_header_deframer] ERROR");
    end
    $finish;
  end

endmodule
